>>> rtl/pph_pkg.sv
// Package: shared constants, codes and controller/datapath interface types for pulse_period_history.
package pph_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int VALUE_W       = 32;
    localparam int COUNT_W       = 16;
    localparam int ENTRY_W       = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 40;

    localparam logic [VALUE_W-1:0] MIN_PULSE_RST  = 32'd100;
    localparam logic [VALUE_W-1:0] MAX_PULSE_RST  = 32'd1000000;
    localparam logic [COUNT_W-1:0] IDLE_LIMIT_RST = 16'd3000;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

    typedef enum logic [1:0] {
        OP_PULSE = 2'd0,
        OP_TICK  = 2'd1,
        OP_READ  = 2'd2
    } pph_op_t;

    typedef struct packed {
        logic             do_pulse;
        logic             do_tick;
        logic             out_load;
        logic [IDX_W-1:0] rd_idx;
        logic             rd_last;
        logic             clear;
    } pph_cmd_t;

    typedef struct packed {
        logic running;
        logic fresh;
    } pph_stat_t;

endpackage

>>> rtl/pph_ctrl.sv
// Controller: request decode and read sequencing state machine.
module pph_ctrl
    import pph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] op,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  pph_stat_t  stat,
    output pph_cmd_t   cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             accept;
    logic             slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd.do_pulse = 1'b0;
        cmd.do_tick  = 1'b0;
        cmd.out_load = 1'b0;
        cmd.rd_idx   = idx_reg;
        cmd.rd_last  = (idx_reg == LAST_IDX);
        cmd.clear    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (pph_op_t'(op))
                        OP_PULSE: cmd.do_pulse = 1'b1;
                        OP_TICK:  cmd.do_tick  = 1'b1;
                        OP_READ:
                        begin
                            state_next = ST_READ;
                            idx_next   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    if (cmd.rd_last)
                    begin
                        cmd.clear  = stat.running && !stat.fresh;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten while held");

    a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> (cmd.out_load && cmd.rd_last))
        else $error("clear outside final entry of a read");

    a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && cmd.out_load && cmd.rd_last) |=> s_tready)
        else $error("controller did not return to idle after read");
`endif

endmodule

>>> rtl/pph_datapath.sv
// Datapath: config registers, history shift line, idle counter and output register.
module pph_datapath
    import pph_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [VALUE_W-1:0]    capture_value,
    input  pph_cmd_t              cmd,
    output pph_stat_t             stat,
    output logic [VALUE_W-1:0]    history_value,
    output logic [ENTRY_W-1:0]    entry_index,
    output logic                  last_entry,
    output logic                  running,
    output logic                  fresh
);

    logic [VALUE_W-1:0] min_pulse_reg;
    logic [VALUE_W-1:0] max_pulse_reg;
    logic [COUNT_W-1:0] idle_limit_reg;

    logic [VALUE_W-1:0] hist_reg [HISTORY_DEPTH];
    logic [COUNT_W-1:0] idle_count_reg, idle_count_next;
    logic               seen_reg, seen_next;

    logic [VALUE_W-1:0] out_value_reg;
    logic [ENTRY_W-1:0] out_index_reg;
    logic               out_last_reg;
    logic               out_running_reg;
    logic               out_fresh_reg;

    logic [VALUE_W-1:0] repl_value;
    logic [VALUE_W-1:0] new_value;
    logic               shift_en;

    assign stat.running = seen_reg;
    assign stat.fresh   = seen_reg && (idle_count_reg < idle_limit_reg);

    // low capture repeats the previous newest entry, then saturate
    assign repl_value = (capture_value < min_pulse_reg) ? hist_reg[0] : capture_value;
    assign new_value  = (repl_value > max_pulse_reg) ? max_pulse_reg : repl_value;
    assign shift_en   = cmd.do_pulse && seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg  <= MIN_PULSE_RST;
            max_pulse_reg  <= MAX_PULSE_RST;
            idle_limit_reg <= IDLE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_PULSE:  min_pulse_reg  <= cfg_data;
                CFG_MAX_PULSE:  max_pulse_reg  <= cfg_data;
                CFG_IDLE_LIMIT: idle_limit_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        idle_count_next = idle_count_reg;
        seen_next       = seen_reg;
        if (cmd.clear)
        begin
            idle_count_next = '0;
            seen_next       = 1'b0;
        end
        else if (cmd.do_pulse)
        begin
            idle_count_next = '0;
            seen_next       = 1'b1;
        end
        else if (cmd.do_tick)
        begin
            if (!seen_reg)
                idle_count_next = '0;
            else if (idle_count_reg < idle_limit_reg)
                idle_count_next = idle_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_count_reg <= '0;
            seen_reg       <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            idle_count_reg <= idle_count_next;
            seen_reg       <= seen_next;
            if (cmd.clear)
            begin
                for (int i = 0; i < HISTORY_DEPTH; i++)
                    hist_reg[i] <= '0;
            end
            else if (shift_en)
            begin
                for (int i = HISTORY_DEPTH - 1; i > 0; i--)
                    hist_reg[i] <= hist_reg[i-1];
                hist_reg[0] <= new_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg   <= seen_reg ? hist_reg[cmd.rd_idx] : '0;
            out_index_reg   <= ENTRY_W'(cmd.rd_idx);
            out_last_reg    <= cmd.rd_last;
            out_running_reg <= stat.running;
            out_fresh_reg   <= stat.fresh;
        end
    end

    assign history_value = out_value_reg;
    assign entry_index   = out_index_reg;
    assign last_entry    = out_last_reg;
    assign running       = out_running_reg;
    assign fresh         = out_fresh_reg;

`ifndef SYNTHESIS
    a_clear_stops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> !seen_reg && (idle_count_reg == '0))
        else $error("clear did not reset running state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_tick && !cmd.clear && (idle_count_reg >= idle_limit_reg))
            |=> $stable(idle_count_reg))
        else $error("idle counter passed its limit");

    a_shift_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (shift_en && !cmd.clear) |=> (hist_reg[1] == $past(hist_reg[0])))
        else $error("history did not shift on pulse");
`endif

endmodule

>>> rtl/pulse_period_history.sv
// Top level: pulse period history with stream ports and config write port.
// Pulse and tick requests are handled in the cycle they are accepted; s_tready stays high after them.
// A read request streams HISTORY_DEPTH entries: on acceptance the controller enters ST_READ,
// which loads the output register that sets m_tvalid; entries then follow one per cycle while
// m_tready is high. s_tready stays low until the read has loaded its last entry.
// rst_n clears history, idle counter and running flag, and loads register defaults.
module pulse_period_history
    import pph_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] capture_value
    input  logic [1:0]             s_tuser,   // [1:0] opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] history_value, [37:32] entry_index
    output logic [1:0]             m_tuser,   // [0] running, [1] fresh
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    pph_cmd_t           cmd;
    pph_stat_t          stat;
    logic [VALUE_W-1:0] history_value;
    logic [ENTRY_W-1:0] entry_index;
    logic               running;
    logic               fresh;

    pph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pph_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .capture_value (s_tdata[VALUE_W-1:0]),
        .cmd           (cmd),
        .stat          (stat),
        .history_value (history_value),
        .entry_index   (entry_index),
        .last_entry    (m_tlast),
        .running       (running),
        .fresh         (fresh)
    );

    assign m_tdata = {{(OUT_TDATA_W - VALUE_W - ENTRY_W){1'b0}}, entry_index, history_value};
    assign m_tuser = {fresh, running};

endmodule
